>>> rtl/ile_pkg.sv
// ile_pkg: shared constants, operation codes and cell control type
// for the indexed list engine; no dependencies
package ile_pkg;

  localparam int DEPTH = 64;
  localparam int WIDTH = 32;

  // fixed field widths of the channels
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int FILL_W = 7;

  // entry count holds 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);
  // common width for comparing positions, counts and cell indices
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_ERASE  = 3'd5
  } op_e;

  typedef logic [WIDTH-1:0] word_t;

  // per-cell control for one beat
  typedef struct packed {
    logic load;     // take the incoming word
    logic take_lo;  // take the lower neighbor's word (insert shift)
    logic take_hi;  // take the upper neighbor's word (erase shift)
    logic rd_sel;   // drive this entry onto the read bus
  } cell_ctrl_t;

endpackage

>>> rtl/ile_in_if.sv
// ile_in_if: operation channel of the indexed list engine
// depends on ile_pkg for field widths
interface ile_in_if;
  logic                      valid;
  logic                      ready;
  logic [ile_pkg::OP_W-1:0]  op;
  logic [ile_pkg::POS_W-1:0] position;
  logic [ile_pkg::VAL_W-1:0] value_in;

  modport source (output valid, output op, output position, output value_in, input ready);
  modport sink   (input valid, input op, input position, input value_in, output ready);
endinterface

>>> rtl/ile_out_if.sv
// ile_out_if: result channel of the indexed list engine
// depends on ile_pkg for field widths
interface ile_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [ile_pkg::VAL_W-1:0]  value_out;
  logic [ile_pkg::FILL_W-1:0] fill;

  modport source (output valid, output ok, output value_out, output fill, input ready);
  modport sink   (input valid, input ok, input value_out, input fill, output ready);
endinterface

>>> rtl/ile_cell.sv
// ile_cell: one entry of the list, loads, shifts from a neighbor or holds
// depends on ile_pkg for the word and control types
module ile_cell (
  input  logic                clk_i,
  input  ile_pkg::cell_ctrl_t ctrl_i,
  input  ile_pkg::word_t      word_i,
  input  ile_pkg::word_t      lo_i,
  input  ile_pkg::word_t      hi_i,
  output ile_pkg::word_t      data_o,
  output ile_pkg::word_t      rd_o
);

  ile_pkg::word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = word_i;
    end else if (ctrl_i.take_lo) begin
      data_d = lo_i;
    end else if (ctrl_i.take_hi) begin
      data_d = hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = ctrl_i.rd_sel ? data_q : '0;

endmodule

>>> rtl/indexed_list_engine_top.sv
// indexed_list_engine_top: ordered list of entry cells with a count,
// push, pop, get, set, insert and erase; uses ile_pkg, ile_in_if, ile_out_if, ile_cell
//
// The list is a row of DEPTH entry cells that all update in the same clock,
// so insert and erase move every later entry by one place at once. One
// operation is taken per clock unless a waiting result is stalled by the
// sink; its result beat comes out of a register in the cycle after
// acceptance, and a new operation is taken while that result waits as long
// as the sink takes it in the same cycle. The rate rests on the row update
// and the read select over the cells. Entry contents are not cleared by
// reset, only the count and output valid; reads stay below the count.
module indexed_list_engine_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ile_in_if.sink    in_i,
  ile_out_if.source out_o
);

  localparam int D = ile_pkg::DEPTH;

  logic [ile_pkg::CNT_W-1:0] used_q, used_d, used_m1;
  logic [ile_pkg::CMP_W-1:0] pos_x, used_x, rd_idx;
  ile_pkg::word_t            word;
  ile_pkg::op_e              op;
  logic                      accept, ok;
  logic                      not_full, not_empty, pos_lt, pos_le;
  logic                      do_push, do_set, do_ins, do_era, rd_en;

  logic                        out_valid_q;
  logic                        ok_q;
  logic [ile_pkg::VAL_W-1:0]   value_q;
  logic [ile_pkg::FILL_W-1:0]  fill_q;

  ile_pkg::word_t     cell_data [D];
  ile_pkg::word_t     cell_rd   [D];
  ile_pkg::cell_ctrl_t ctrl     [D];
  ile_pkg::word_t     rd_bus;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign op      = ile_pkg::op_e'(in_i.op);
  assign word    = ile_pkg::WIDTH'(in_i.value_in);
  assign pos_x   = ile_pkg::CMP_W'(in_i.position);
  assign used_x  = ile_pkg::CMP_W'(used_q);
  assign used_m1 = used_q - ile_pkg::CNT_W'(1);

  assign not_full  = used_q < ile_pkg::CNT_W'(D);
  assign not_empty = used_q != '0;
  assign pos_lt    = pos_x < used_x;
  assign pos_le    = pos_x <= used_x;

  // operation decode and count update
  always_comb begin
    ok      = 1'b0;
    do_push = 1'b0;
    do_set  = 1'b0;
    do_ins  = 1'b0;
    do_era  = 1'b0;
    rd_en   = 1'b0;
    rd_idx  = pos_x;
    used_d  = used_q;
    unique case (op)
      ile_pkg::OP_PUSH: begin
        ok      = not_full;
        do_push = not_full;
        if (not_full) used_d = used_q + ile_pkg::CNT_W'(1);
      end
      ile_pkg::OP_POP: begin
        ok     = not_empty;
        rd_en  = not_empty;
        rd_idx = ile_pkg::CMP_W'(used_m1);
        if (not_empty) used_d = used_m1;
      end
      ile_pkg::OP_GET: begin
        ok    = pos_lt;
        rd_en = pos_lt;
      end
      ile_pkg::OP_SET: begin
        ok     = pos_lt;
        do_set = pos_lt;
      end
      ile_pkg::OP_INSERT: begin
        ok     = pos_le && not_full;
        do_ins = pos_le && not_full;
        if (pos_le && not_full) used_d = used_q + ile_pkg::CNT_W'(1);
      end
      ile_pkg::OP_ERASE: begin
        ok     = pos_lt;
        do_era = pos_lt;
        if (pos_lt) used_d = used_m1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // row of entry cells
  for (genvar i = 0; i < D; i++) begin : g_cell
    localparam logic [ile_pkg::CMP_W-1:0] IDX = ile_pkg::CMP_W'(i);
    ile_pkg::word_t lo, hi;

    if (i == 0) begin : g_lo0
      assign lo = '0;
    end else begin : g_lo
      assign lo = cell_data[i-1];
    end
    if (i == D - 1) begin : g_hin
      assign hi = '0;
    end else begin : g_hi
      assign hi = cell_data[i+1];
    end

    always_comb begin
      ctrl[i].load    = accept && (((do_set || do_ins) && (IDX == pos_x)) ||
                                   (do_push && (IDX == used_x)));
      ctrl[i].take_lo = accept && do_ins && (IDX > pos_x) && (IDX <= used_x);
      ctrl[i].take_hi = accept && do_era && (IDX >= pos_x) &&
                        ((IDX + ile_pkg::CMP_W'(1)) < used_x);
      ctrl[i].rd_sel  = rd_en && (IDX == rd_idx);
    end

    ile_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl[i]),
      .word_i (word),
      .lo_i   (lo),
      .hi_i   (hi),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  // at most one cell drives a nonzero word
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < D; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        used_q      <= used_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q    <= ok;
      value_q <= ile_pkg::VAL_W'(rd_bus);
      fill_q  <= ile_pkg::FILL_W'(used_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ok        = ok_q;
  assign out_o.value_out = value_q;
  assign out_o.fill      = fill_q;

endmodule

>>> tb/testbench.sv
// testbench: random and directed operation stream for indexed_list_engine_top,
// checked beat by beat against a list model kept here
// depends on ile_pkg, ile_in_if, ile_out_if and the engine rtl
module testbench;

  // op codes the engine must reject
  localparam logic [ile_pkg::OP_W-1:0] OP_RESERVED_A = 3'd6;
  localparam logic [ile_pkg::OP_W-1:0] OP_RESERVED_B = 3'd7;

  typedef struct {
    logic [ile_pkg::OP_W-1:0]  op;
    logic [ile_pkg::POS_W-1:0] position;
    logic [ile_pkg::VAL_W-1:0] value_in;
    bit                        wait_idle;  // hold this beat until every result is back
  } list_op_t;

  typedef struct {
    logic                       ok;
    logic [ile_pkg::VAL_W-1:0]  value_out;
    logic [ile_pkg::FILL_W-1:0] fill;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  ile_in_if  ops_if ();
  ile_out_if results_if ();

  indexed_list_engine_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ops_if),
    .out_o  (results_if)
  );

  list_op_t     queued_ops[$];
  list_result_t due_results[$];

  // model copy of the list
  ile_pkg::word_t list_words[ile_pkg::DEPTH];
  int unsigned    list_len;

  // entry count as the generator sees it, used to aim positions and to end the fill and drain runs
  int unsigned gen_len;

  int unsigned  n_accepted;
  int unsigned  n_errors;
  int           burst_left;
  int           gap_left;
  int unsigned  rx_cycle;
  logic         hold_off;
  logic         offer;
  list_result_t want;

  function automatic list_result_t apply_list_op(list_op_t item);
    list_result_t r;
    int unsigned pos;
    r.ok        = 1'b0;
    r.value_out = '0;
    pos = item.position;
    case (item.op)
      ile_pkg::OP_PUSH: if (list_len < ile_pkg::DEPTH) begin
        list_words[list_len] = item.value_in[ile_pkg::WIDTH-1:0];
        list_len++;
        r.ok = 1'b1;
      end
      ile_pkg::OP_POP: if (list_len > 0) begin
        list_len--;
        r.value_out = list_words[list_len];
        r.ok = 1'b1;
      end
      ile_pkg::OP_GET: if (pos < list_len) begin
        r.value_out = list_words[pos];
        r.ok = 1'b1;
      end
      ile_pkg::OP_SET: if (pos < list_len) begin
        list_words[pos] = item.value_in[ile_pkg::WIDTH-1:0];
        r.ok = 1'b1;
      end
      ile_pkg::OP_INSERT: if (pos <= list_len && list_len < ile_pkg::DEPTH) begin
        for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
        list_words[pos] = item.value_in[ile_pkg::WIDTH-1:0];
        list_len++;
        r.ok = 1'b1;
      end
      ile_pkg::OP_ERASE: if (pos < list_len) begin
        for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
        list_len--;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.fill = ile_pkg::FILL_W'(list_len);
    return r;
  endfunction

  task automatic add_op(input logic [ile_pkg::OP_W-1:0] op, input int unsigned pos,
                        input logic [ile_pkg::VAL_W-1:0] val, input bit wait_idle = 1'b0);
    list_op_t item;
    item.op        = op;
    item.position  = pos[ile_pkg::POS_W-1:0];
    item.value_in  = val;
    // fixed points in the stream where the sender drains everything first
    item.wait_idle = wait_idle || queued_ops.size() == 24 || queued_ops.size() == 700;
    queued_ops.push_back(item);
    case (op)
      ile_pkg::OP_PUSH:   if (gen_len < ile_pkg::DEPTH) gen_len++;
      ile_pkg::OP_POP:    if (gen_len > 0) gen_len--;
      ile_pkg::OP_INSERT: if (pos <= gen_len && gen_len < ile_pkg::DEPTH) gen_len++;
      ile_pkg::OP_ERASE:  if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic [ile_pkg::VAL_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: bursts and gaps, valid held until the beat is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_if.valid    <= 1'b0;
      ops_if.op       <= '0;
      ops_if.position <= '0;
      ops_if.value_in <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!(ops_if.valid && !ops_if.ready)) begin
      if (ops_if.valid && ops_if.ready) begin
        due_results.push_back(apply_list_op(queued_ops[0]));
        void'(queued_ops.pop_front());
        n_accepted++;
      end
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (queued_ops.size() > 0 &&
                   !(queued_ops[0].wait_idle && due_results.size() > 0)) begin
        offer = 1'b1;
      end
      if (offer) begin
        ops_if.op       <= queued_ops[0].op;
        ops_if.position <= queued_ops[0].position;
        ops_if.value_in <= queued_ops[0].value_in;
        burst_left--;
        if (burst_left <= 0) begin
          // now and then a long burst with no gaps inserted
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                    : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      ops_if.valid <= offer;
    end
  end

  // receiver: check each result beat, stall on a rotating pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      results_if.ready <= 1'b0;
      rx_cycle = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat: ok %0b value_out %h fill %0d", $time,
                   results_if.ok, results_if.value_out, results_if.fill);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          if (results_if.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, results_if.ok);
            n_errors++;
          end
          if (results_if.value_out !== want.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time,
                     want.value_out, results_if.value_out);
            n_errors++;
          end
          if (results_if.fill !== want.fill) begin
            $display("%0t: fill expected %0d actual %0d", $time, want.fill, results_if.fill);
            n_errors++;
          end
        end
      end
      rx_cycle++;
      case ((rx_cycle / 80) % 4)
        0: results_if.ready <= !hold_off;
        1: results_if.ready <= !hold_off && ($urandom_range(0, 1) == 1);
        2: results_if.ready <= !hold_off && ($urandom_range(0, 3) != 0);
        default: results_if.ready <= !hold_off && ((rx_cycle % 5) < 2);
      endcase
    end
  end

  // long receiver hold-off while the sender keeps pushing
  initial begin
    hold_off = 1'b0;
    wait (n_accepted >= 200);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("indexed_list_engine_top: mismatch");
    $finish;
  end

  initial begin
    int unsigned                 pos;
    int unsigned                 sel;
    logic [ile_pkg::OP_W-1:0]    op;

    list_len   = 0;
    gen_len    = 0;
    n_accepted = 0;
    n_errors   = 0;

    // directed: empty list, bad indices, both ends, reserved codes
    add_op(ile_pkg::OP_POP, 0, '0);
    add_op(ile_pkg::OP_GET, 0, '0);
    add_op(ile_pkg::OP_SET, 0, 32'h1111_1111);
    add_op(ile_pkg::OP_ERASE, 0, '0);
    add_op(ile_pkg::OP_INSERT, 1, 32'h2222_2222);
    add_op(ile_pkg::OP_INSERT, 0, '1);
    add_op(ile_pkg::OP_PUSH, 0, '0);
    add_op(ile_pkg::OP_PUSH, 127, 32'hA5A5_A5A5);
    add_op(ile_pkg::OP_INSERT, 3, 32'h5A5A_5A5A);  // at the count: append
    add_op(ile_pkg::OP_INSERT, 1, 32'h1234_5678);
    add_op(ile_pkg::OP_GET, 0, '1);
    add_op(ile_pkg::OP_GET, 4, '0);
    add_op(ile_pkg::OP_GET, 5, '0);
    add_op(ile_pkg::OP_GET, 127, '0);
    add_op(ile_pkg::OP_SET, 2, 32'hDEAD_BEEF);
    add_op(ile_pkg::OP_SET, 5, 32'hFFFF_0000);
    add_op(ile_pkg::OP_GET, 2, '0);
    add_op(ile_pkg::OP_ERASE, 0, '0);
    add_op(ile_pkg::OP_ERASE, 3, '0);
    add_op(ile_pkg::OP_ERASE, 127, '0);
    add_op(OP_RESERVED_A, 127, '1);
    add_op(OP_RESERVED_B, 0, '0);
    add_op(ile_pkg::OP_POP, 0, '0);
    add_op(ile_pkg::OP_POP, 64, '0);

    while (queued_ops.size() < 1200) begin
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
        // fill to capacity, then push and insert against the full list
        while (gen_len < ile_pkg::DEPTH) begin
          if ($urandom_range(0, 1)) begin
            add_op(ile_pkg::OP_PUSH, $urandom_range(0, 127), pick_word());
          end else begin
            add_op(ile_pkg::OP_INSERT, $urandom_range(0, gen_len), pick_word());
          end
        end
        add_op(ile_pkg::OP_PUSH, 0, pick_word());
        add_op(ile_pkg::OP_INSERT, $urandom_range(0, ile_pkg::DEPTH), pick_word());
      end else if (sel == 1) begin
        // drain to empty, then pull from the empty list
        while (gen_len > 0) begin
          if ($urandom_range(0, 1)) begin
            add_op(ile_pkg::OP_POP, $urandom_range(0, 127), pick_word());
          end else begin
            add_op(ile_pkg::OP_ERASE, $urandom_range(0, gen_len - 1), pick_word());
          end
        end
        add_op(ile_pkg::OP_POP, 0, pick_word());
        add_op(ile_pkg::OP_ERASE, 0, pick_word());
      end else begin
        repeat ($urandom_range(10, 40)) begin
          sel = $urandom_range(0, 40);
          if (sel == 40) op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
          else op = ile_pkg::OP_W'(sel % 6);
          sel = $urandom_range(0, 9);
          if (sel == 0) pos = $urandom_range(0, 127);
          else if (sel == 1) pos = gen_len + $urandom_range(0, 1);
          else if (op == ile_pkg::OP_INSERT) pos = $urandom_range(0, gen_len);
          else pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
          add_op(op, pos, pick_word());
        end
      end
    end

    rst_ni = 1'b1;
    #1 rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (queued_ops.size() == 0);
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("indexed_list_engine_top: match");
    end else begin
      $display("indexed_list_engine_top: mismatch");
    end
    $finish;
  end

endmodule
